@@ rtl/kwm_pkg.sv @@
// Shared types and codes for the k-way sorted merge core.
// Used by kwm_ctrl, kwm_dpath and k_way_sorted_merge_core; depends on nothing.
package kwm_pkg;

	// Command codes carried in the low tuser bit of an input word.
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_PUSHED  = 2'd0,
		ST_DROPPED = 2'd1,
		ST_POPPED  = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_REFILL,
		S_SETTLE,
		S_RESP
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // register the accepted input word
		logic exec;      // apply the push or pop, form the result
		logic refill;    // load the refetched head into its register
		logic load_out;  // move the result into the output register
	} ctl_t;

	// Status from the datapath to the controller, valid during S_EXEC.
	typedef struct packed {
		logic is_pop;       // the held word is a pop
		logic found;        // at least one queue is non-empty
		logic need_refill;  // the winning queue keeps entries after the pop
	} sts_t;

endpackage

@@ rtl/k_way_sorted_merge_core.sv @@
// K-way sorted merge core. Input words push a value onto one of NUM_LISTS
// FIFO queues or pop the smallest head over all queues (ties: lowest list).
// Each accepted word yields exactly one result word on the master side.
// Input word: s_tuser[0] = cmd (0 push, 1 pop), s_tuser[3:1] = list_sel,
// s_tdata = data_in (signed, ignored on pop).
// Result word: m_tuser[1:0] = status (0 pushed, 1 dropped, 2 popped, 3 empty),
// m_tuser[4:2] = source_list, m_tdata = data_out; both zero unless popped.
// Timing: an accepted word passes through S_EXEC, S_SETTLE and S_RESP; a
// pop that refetches a head from the queue memory also passes S_REFILL.
// m_tvalid rises once the result is loaded, and s_tready returns with it.
// The settle wait is set by the registered minimum tree, one level per cycle,
// which must settle on new heads before the next pop reads its root.
// One word is in work at a time.
// The result sits in an output register, so a stalled receiver holds only
// that word; the next input is accepted and worked on meanwhile, and waits
// in the result stage until the output register frees up.
// Reset (arst_n low) empties all queues; no clearing pass is needed.
module k_way_sorted_merge_core #(
	parameter int NUM_LISTS   = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] data_in
	input  logic [3:0]  s_tuser,   // [0] cmd, [3:1] list_sel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] data_out
	output logic [4:0]  m_tuser    // [1:0] status, [4:2] source_list
);

	kwm_pkg::ctl_t ctl;
	kwm_pkg::sts_t sts;

	kwm_ctrl #(
		.SETTLE_CYCLES ($clog2(NUM_LISTS))
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.sts       (sts),
		.ctl       (ctl)
	);

	kwm_dpath #(
		.NUM_LISTS   (NUM_LISTS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.sts     (sts),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

`ifndef ASSERT_OFF
	// The held word is loaded only on an accepted input word.
	a_capture_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.capture |-> (s_tvalid && s_tready))
		else $error("input word captured without a handshake");

	// A loaded result is presented on the next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |=> m_tvalid)
		else $error("loaded result not presented");

	// A head refill always directly follows the pop that needs it.
	a_refill_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.refill |-> $past(ctl.exec))
		else $error("head refill without a preceding pop");

	// Anything but a successful pop carries zero data and source list.
	a_nonpop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser[1:0] != kwm_pkg::ST_POPPED))
			|-> (m_tdata == 32'd0 && m_tuser[4:2] == 3'd0))
		else $error("non-pop result carries data");
`endif

endmodule

@@ rtl/kwm_ctrl.sv @@
// Controller state machine of the k-way sorted merge core.
// Sequences accept, execute, head refill, tree settle and result hand-off.
// Depends on kwm_pkg.
module kwm_ctrl #(
	parameter int SETTLE_CYCLES = 3
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  kwm_pkg::sts_t  sts,
	output kwm_pkg::ctl_t  ctl
);

	localparam int CNTW = $clog2(SETTLE_CYCLES + 1);

	kwm_pkg::state_t state_q, state_d;
	logic [CNTW-1:0] cnt_q, cnt_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// State and settle counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kwm_pkg::S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// Output word valid flag: set when a result is loaded, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		ctl      = '0;
		in_ready = 1'b0;
		case (state_q)
			kwm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = kwm_pkg::S_EXEC;
				end
			end
			kwm_pkg::S_EXEC: begin
				ctl.exec = 1'b1;
				cnt_d    = CNTW'(SETTLE_CYCLES - 1);
				if (sts.is_pop && sts.found && sts.need_refill) begin
					state_d = kwm_pkg::S_REFILL;
				end else begin
					state_d = kwm_pkg::S_SETTLE;
				end
			end
			kwm_pkg::S_REFILL: begin
				ctl.refill = 1'b1;
				state_d    = kwm_pkg::S_SETTLE;
			end
			kwm_pkg::S_SETTLE: begin
				// Let the registered minimum tree absorb the new heads.
				if (cnt_q == '0) begin
					state_d = kwm_pkg::S_RESP;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			kwm_pkg::S_RESP: begin
				if (out_free) begin
					ctl.load_out = 1'b1;
					state_d      = kwm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = kwm_pkg::S_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/kwm_dpath.sv @@
// Datapath of the k-way sorted merge core: queue memory, per-list pointers,
// head registers, registered minimum tree and result/output registers.
// Depends on kwm_pkg.
module kwm_dpath #(
	parameter int NUM_LISTS   = 8,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  kwm_pkg::ctl_t  ctl,
	output kwm_pkg::sts_t  sts,
	input  logic [31:0]    s_tdata,
	input  logic [3:0]     s_tuser,
	output logic [31:0]    m_tdata,
	output logic [4:0]     m_tuser
);

	localparam int LW = $clog2(NUM_LISTS);
	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int P  = 1 << LW;
	localparam int AW = LW + PW;

	// Held input word.
	logic               cmd_q;
	logic [2:0]         sel_q;
	logic signed [31:0] data_q;

	// Per-list state, padded to a power of two; padded lists stay empty.
	logic [PW-1:0]      rd_q   [P];
	logic [PW-1:0]      wr_q   [P];
	logic [CW-1:0]      fill_q [P];
	logic               hv_q   [P];
	logic signed [31:0] head_q [P];

	// Queue memory, addressed by list and slot.
	logic signed [31:0] mem [1 << AW];
	logic signed [31:0] rdata_q;

	// Minimum tree: registered inner nodes, leaves taken from the heads.
	logic               nv_q [1:P-1];
	logic signed [31:0] nk_q [1:P-1];
	logic [LW-1:0]      ni_q [1:P-1];
	logic               tv [1:2*P-1];
	logic signed [31:0] tk [1:2*P-1];
	logic [LW-1:0]      ti [1:2*P-1];

	// Result and output registers.
	kwm_pkg::status_t   res_status_q, out_status_q;
	logic signed [31:0] res_data_q, out_data_q;
	logic [2:0]         res_src_q, out_src_q;
	logic [LW-1:0]      best_q;

	logic               is_pop, sel_ok, push_ok, found, need_refill;
	logic [LW-1:0]      sidx, best;
	logic [PW-1:0]      rd_next, wr_next;

	// Capture the accepted word: tuser holds cmd then list_sel.
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q  <= s_tuser[0];
			sel_q  <= s_tuser[3:1];
			data_q <= s_tdata;
		end
	end

	// Decode of the held word against the current state.
	assign is_pop      = (cmd_q == kwm_pkg::CMD_POP);
	assign sel_ok      = (int'(sel_q) < NUM_LISTS);
	assign sidx        = LW'(sel_q);
	assign push_ok     = sel_ok && (fill_q[sidx] != CW'(QUEUE_DEPTH));
	assign found       = tv[1];
	assign best        = ti[1];
	assign need_refill = fill_q[best] > CW'(1);
	assign rd_next     = (rd_q[best] == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q[best] + 1'b1;
	assign wr_next     = (wr_q[sidx] == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q[sidx] + 1'b1;

	assign sts.is_pop      = is_pop;
	assign sts.found       = found;
	assign sts.need_refill = need_refill;

	// Tree view: inner nodes from registers, leaves from the head registers.
	always_comb begin
		for (int i = 1; i < P; i++) begin
			tv[i] = nv_q[i];
			tk[i] = nk_q[i];
			ti[i] = ni_q[i];
		end
		for (int k = 0; k < P; k++) begin
			tv[P+k] = hv_q[k];
			tk[P+k] = head_q[k];
			ti[P+k] = LW'(k);
		end
	end

	// One registered compare per node; the left child wins ties (lower list).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i < P; i++) begin
				nv_q[i] <= 1'b0;
			end
		end else begin
			for (int i = 1; i < P; i++) begin
				nv_q[i] <= tv[2*i] || tv[2*i+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 1; i < P; i++) begin
			if (tv[2*i] && (!tv[2*i+1] || tk[2*i] <= tk[2*i+1])) begin
				nk_q[i] <= tk[2*i];
				ni_q[i] <= ti[2*i];
			end else begin
				nk_q[i] <= tk[2*i+1];
				ni_q[i] <= ti[2*i+1];
			end
		end
	end

	// Pointers, fill counts and head valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < P; k++) begin
				rd_q[k]   <= '0;
				wr_q[k]   <= '0;
				fill_q[k] <= '0;
				hv_q[k]   <= 1'b0;
			end
		end else if (ctl.exec) begin
			if (!is_pop && push_ok) begin
				wr_q[sidx]   <= wr_next;
				fill_q[sidx] <= fill_q[sidx] + 1'b1;
				hv_q[sidx]   <= 1'b1;
			end else if (is_pop && found) begin
				rd_q[best]   <= rd_next;
				fill_q[best] <= fill_q[best] - 1'b1;
				if (!need_refill) begin
					hv_q[best] <= 1'b0;
				end
			end
		end
	end

	// Head values: a push into an empty queue sets the head directly,
	// a pop that leaves entries behind reloads it from the memory.
	always_ff @(posedge clk) begin
		if (ctl.exec && !is_pop && push_ok && !hv_q[sidx]) begin
			head_q[sidx] <= data_q;
		end else if (ctl.refill) begin
			head_q[best_q] <= rdata_q;
		end
	end

	// Queue memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (ctl.exec && !is_pop && push_ok) begin
			mem[{sidx, wr_q[sidx]}] <= data_q;
		end
		rdata_q <= mem[{best, rd_next}];
	end

	// Result word formed while executing.
	always_ff @(posedge clk) begin
		if (ctl.exec) begin
			best_q     <= best;
			res_data_q <= '0;
			res_src_q  <= '0;
			if (!is_pop) begin
				res_status_q <= push_ok ? kwm_pkg::ST_PUSHED : kwm_pkg::ST_DROPPED;
			end else if (found) begin
				res_status_q <= kwm_pkg::ST_POPPED;
				res_data_q   <= tk[1];
				res_src_q    <= 3'(best);
			end else begin
				res_status_q <= kwm_pkg::ST_EMPTY;
			end
		end
	end

	// Output register, decoupled from the working result.
	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_status_q <= res_status_q;
			out_data_q   <= res_data_q;
			out_src_q    <= res_src_q;
		end
	end

	assign m_tdata = out_data_q;
	assign m_tuser = {out_src_q, out_status_q};

endmodule

@@ sim/tb_k_way_sorted_merge_core.sv @@
// Self-checking testbench for k_way_sorted_merge_core: directed rows, then random
// push/pop traffic, each result compared with an in-bench merge predictor or a typed expectation.
// Depends on rtl/kwm_pkg.sv and rtl/k_way_sorted_merge_core.sv.
module tb_k_way_sorted_merge_core;

	localparam int LISTS       = 8;
	localparam int DEPTH       = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASES      = 12;
	localparam int PHASE_WORDS = 155;
	localparam int DIR_ROWS    = 16;

	// One result word as the block reports it.
	typedef struct packed {
		kwm_pkg::status_t status;
		logic [31:0]      value;
		logic [2:0]       src;
	} merge_res_t;

	// One input word, with an optional hand-written expectation.
	typedef struct packed {
		logic        cmd;
		logic [2:0]  sel;
		logic [31:0] data;
		logic        typed;
		merge_res_t  want;
	} stim_word_t;

	// Directed row: the data field counts up across repeats.
	typedef struct packed {
		logic        cmd;
		logic [2:0]  sel;
		logic [31:0] data;
		logic [4:0]  reps;
		logic        typed;
		merge_res_t  want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = 32'd0;
	logic [3:0]  s_tuser = 4'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [4:0]  m_tuser;

	// Predictor copy of the per-list queues.
	logic [31:0] lane_mem [LISTS][DEPTH];
	int          head_idx [LISTS];
	int          tail_idx [LISTS];
	int          lane_fill [LISTS];

	merge_res_t  pending_results [$];
	stim_word_t  stim_q [$];
	dir_row_t    dir_tab [DIR_ROWS];
	int          err_cnt = 0;
	int          cycle_cnt = 0;

	k_way_sorted_merge_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit; a hang ends here.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("%0t: run limit reached", $time);
			$display("tb_k_way_sorted_merge_core: done, errors");
			$finish;
		end
	end

	// Applies one word to the predictor state and returns the result it causes.
	function automatic merge_res_t merge_predict(input logic cmd, input logic [2:0] sel,
			input logic [31:0] din);
		merge_res_t r;
		int best;
		int k;
		r = '{kwm_pkg::ST_PUSHED, 32'd0, 3'd0};
		if (cmd == kwm_pkg::CMD_PUSH) begin
			if (lane_fill[sel] >= DEPTH) begin
				r.status = kwm_pkg::ST_DROPPED;
			end else begin
				lane_mem[sel][tail_idx[sel]] = din;
				tail_idx[sel] = (tail_idx[sel] + 1) % DEPTH;
				lane_fill[sel] = lane_fill[sel] + 1;
			end
		end else begin
			best = -1;
			// Strict less-than keeps the lowest list on equal heads.
			for (k = 0; k < LISTS; k++) begin
				if (lane_fill[k] != 0 && (best < 0 ||
						$signed(lane_mem[k][head_idx[k]]) <
						$signed(lane_mem[best][head_idx[best]])))
					best = k;
			end
			if (best < 0) begin
				r.status = kwm_pkg::ST_EMPTY;
			end else begin
				r.status = kwm_pkg::ST_POPPED;
				r.value = lane_mem[best][head_idx[best]];
				r.src = best[2:0];
				head_idx[best] = (head_idx[best] + 1) % DEPTH;
				lane_fill[best] = lane_fill[best] - 1;
			end
		end
		return r;
	endfunction

	// Idle cycles before the next word: none, any, or mostly none.
	function automatic int draw_gap(input int mode);
		if (mode == 0)
			return 0;
		if (mode == 1)
			return $urandom_range(0, 14);
		return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
	endfunction

	// Result side: random back-pressure and the field-by-field check.
	initial begin : result_sink
		int gap;
		int mode;
		int n;
		merge_res_t want;
		n = 0;
		mode = 0;
		forever begin
			if (n % 40 == 0)
				mode = $urandom_range(0, 2);
			gap = draw_gap(mode);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, got status %0d data %h list %0d",
					$time, m_tuser[1:0], m_tdata, m_tuser[4:2]);
				err_cnt++;
			end else begin
				want = pending_results.pop_front();
				if (m_tuser[1:0] !== want.status) begin
					$display("%0t: status expected %0d, got %0d", $time, want.status, m_tuser[1:0]);
					err_cnt++;
				end
				if (m_tdata !== want.value) begin
					$display("%0t: data_out expected %h, got %h", $time, want.value, m_tdata);
					err_cnt++;
				end
				if (m_tuser[4:2] !== want.src) begin
					$display("%0t: source_list expected %0d, got %0d", $time, want.src, m_tuser[4:2]);
					err_cnt++;
				end
			end
			n++;
		end
	end

	// Stimulus build, input side and end of run.
	initial begin : word_source
		stim_word_t w;
		merge_res_t r;
		logic [31:0] run_val [LISTS];
		logic [31:0] corner_vals [4];
		int push_pct;
		int lanes_hi;
		int step_cap;
		int pick;
		int gap;
		int mode;
		int n;
		int i;
		int ph;

		for (i = 0; i < LISTS; i++) begin
			head_idx[i] = 0;
			tail_idx[i] = 0;
			lane_fill[i] = 0;
			run_val[i] = 32'd0;
		end
		corner_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF};

		// Directed part: empty pop, both extreme values, a three-way tie,
		// signed order, a full queue with pointer wrap, and drain to empty.
		dir_tab = '{
			'{kwm_pkg::CMD_POP,  3'd0, 32'd0,         5'd1,  1'b1,
				'{kwm_pkg::ST_EMPTY,   32'd0,         3'd0}},
			'{kwm_pkg::CMD_PUSH, 3'd0, 32'h7FFF_FFFF, 5'd1,  1'b1,
				'{kwm_pkg::ST_PUSHED,  32'd0,         3'd0}},
			'{kwm_pkg::CMD_PUSH, 3'd7, 32'h8000_0000, 5'd1,  1'b1,
				'{kwm_pkg::ST_PUSHED,  32'd0,         3'd0}},
			'{kwm_pkg::CMD_POP,  3'd0, 32'd0,         5'd1,  1'b1,
				'{kwm_pkg::ST_POPPED,  32'h8000_0000, 3'd7}},
			'{kwm_pkg::CMD_POP,  3'd0, 32'd0,         5'd1,  1'b1,
				'{kwm_pkg::ST_POPPED,  32'h7FFF_FFFF, 3'd0}},
			'{kwm_pkg::CMD_POP,  3'd7, 32'hFFFF_FFFF, 5'd1,  1'b1,
				'{kwm_pkg::ST_EMPTY,   32'd0,         3'd0}},
			'{kwm_pkg::CMD_PUSH, 3'd5, 32'd5,         5'd1,  1'b0,
				'{kwm_pkg::ST_PUSHED,  32'd0,         3'd0}},
			'{kwm_pkg::CMD_PUSH, 3'd2, 32'd5,         5'd1,  1'b0,
				'{kwm_pkg::ST_PUSHED,  32'd0,         3'd0}},
			'{kwm_pkg::CMD_PUSH, 3'd1, 32'd5,         5'd1,  1'b0,
				'{kwm_pkg::ST_PUSHED,  32'd0,         3'd0}},
			'{kwm_pkg::CMD_PUSH, 3'd6, 32'hFFFF_FFFF, 5'd1,  1'b0,
				'{kwm_pkg::ST_PUSHED,  32'd0,         3'd0}},
			'{kwm_pkg::CMD_PUSH, 3'd4, 32'd0,         5'd1,  1'b0,
				'{kwm_pkg::ST_PUSHED,  32'd0,         3'd0}},
			'{kwm_pkg::CMD_POP,  3'd0, 32'd0,         5'd5,  1'b0,
				'{kwm_pkg::ST_PUSHED,  32'd0,         3'd0}},
			'{kwm_pkg::CMD_PUSH, 3'd3, 32'd100,       5'd16, 1'b0,
				'{kwm_pkg::ST_PUSHED,  32'd0,         3'd0}},
			'{kwm_pkg::CMD_PUSH, 3'd3, 32'd200,       5'd1,  1'b1,
				'{kwm_pkg::ST_DROPPED, 32'd0,         3'd0}},
			'{kwm_pkg::CMD_POP,  3'd0, 32'd0,         5'd16, 1'b0,
				'{kwm_pkg::ST_PUSHED,  32'd0,         3'd0}},
			'{kwm_pkg::CMD_POP,  3'd0, 32'd0,         5'd1,  1'b1,
				'{kwm_pkg::ST_EMPTY,   32'd0,         3'd0}}
		};
		for (i = 0; i < DIR_ROWS; i++) begin
			for (n = 0; n < dir_tab[i].reps; n++) begin
				w.cmd = dir_tab[i].cmd;
				w.sel = dir_tab[i].sel;
				w.data = dir_tab[i].data + n;
				w.typed = dir_tab[i].typed;
				w.want = dir_tab[i].want;
				stim_q.push_back(w);
			end
		end

		// Random part: a filling phase, a draining phase, then mixed phases, with
		// mostly ascending runs per list, some free values and the corners.
		for (ph = 0; ph < PHASES; ph++) begin
			push_pct = (ph == 0) ? 90 : (ph == 1) ? 10 : $urandom_range(15, 85);
			lanes_hi = (ph % 3 == 2) ? $urandom_range(1, 3) : 7;
			case ($urandom_range(0, 3))
				0: step_cap = 0;
				1: step_cap = 2;
				2: step_cap = 255;
				default: step_cap = 32'h00FF_FFFF;
			endcase
			for (i = 0; i < PHASE_WORDS; i++) begin
				w.typed = 1'b0;
				w.want = '{kwm_pkg::ST_PUSHED, 32'd0, 3'd0};
				if ($urandom_range(0, 99) < push_pct) begin
					w.cmd = kwm_pkg::CMD_PUSH;
					w.sel = 3'($urandom_range(0, lanes_hi));
					pick = $urandom_range(0, 99);
					if (pick < 5) begin
						w.data = corner_vals[$urandom_range(0, 3)];
					end else if (pick < 25) begin
						w.data = $urandom();
					end else begin
						w.data = run_val[w.sel] + $urandom_range(0, step_cap);
						// Restart the run where it would wrap past the top.
						if ($signed(w.data) < $signed(run_val[w.sel]))
							w.data = $urandom();
					end
					run_val[w.sel] = w.data;
				end else begin
					w.cmd = kwm_pkg::CMD_POP;
					w.sel = 3'($urandom_range(0, 7));
					w.data = $urandom();
				end
				stim_q.push_back(w);
			end
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Input side: random gaps, each accepted word goes through the predictor.
		mode = 0;
		for (n = 0; n < stim_q.size(); n++) begin
			if (n % 40 == 0)
				mode = $urandom_range(0, 2);
			gap = draw_gap(mode);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			w = stim_q[n];
			s_tvalid <= 1'b1;
			s_tdata <= w.data;
			s_tuser <= {w.sel, w.cmd};
			do @(posedge clk); while (s_tready !== 1'b1);
			r = merge_predict(w.cmd, w.sel, w.data);
			pending_results.push_back(w.typed ? w.want : r);
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("tb_k_way_sorted_merge_core: done, clean");
		else
			$display("tb_k_way_sorted_merge_core: done, errors");
		$finish;
	end

endmodule
